// File: rtl/irps_pkg.sv
// Shared types, constants and table functions for the IR proximity scan builder.
`timescale 1ns / 1ps
package irps_pkg;

  localparam int NUM_SENSORS = 8;
  localparam int NUM_BEAMS   = 21;
  localparam int NUM_POINTS  = 11;

  localparam int INT_W   = 16;  // raw intensity
  localparam int RANGE_W = 27;  // distances and results, micrometres
  localparam int OFFS_W  = 17;  // sensor offset register
  localparam int BEAM_W  = 5;
  localparam int SIDX_W  = 3;   // sensor index
  localparam int SEG_W   = 4;   // table segment / point index
  localparam int PINT_W  = 19;  // table intensities in hundredths
  localparam int P_W     = 23;  // intensity * 100
  localparam int DIST_W  = 17;  // table distances
  localparam int SPAN_W  = 18;  // intensity span of one segment
  localparam int DELTA_W = 15;  // distance step of one segment
  localparam int MUL_W   = DELTA_W + SPAN_W;
  localparam int PROD_W  = 30;  // delta * (hi - p) never exceeds 2^30
  localparam int QUO_W   = 15;  // quotient never exceeds the delta
  localparam int DIV_W   = SPAN_W + QUO_W - 1;
  localparam int STEP_W  = 4;
  localparam int SUM_W   = RANGE_W + 2;

  // floor(x / 3) = (x * RECIP3) >> RECIP_SH for any x below 2^32
  localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;
  localparam int RECIP_SH = 33;
  localparam int MPROD_W  = SUM_W + 32;

  localparam int CFG_W     = 27;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SENSOR_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NO_TARGET     = 2'd1;
  localparam logic [OFFS_W-1:0]  SENSOR_OFFSET_RST = 17'd35000;
  localparam logic [RANGE_W-1:0] NO_TARGET_RST     = 27'd100000000;

  localparam int QDEPTH_DEF = 2;

  localparam logic [PINT_W-1:0] PT_INT [NUM_POINTS] = '{
    19'd409500, 19'd213333, 19'd146573, 19'd60146, 19'd38384, 19'd23493,
    19'd15803,  19'd12000,  19'd10409,  19'd6719,  19'd0};

  localparam logic [DIST_W-1:0] PT_DIST [NUM_POINTS] = '{
    17'd0,     17'd5000,  17'd10000, 17'd15000, 17'd20000, 17'd30000,
    17'd40000, 17'd50000, 17'd60000, 17'd70000, 17'd100000};

  typedef logic [RANGE_W-1:0] range_t;
  typedef range_t [NUM_SENSORS-1:0] frame_t;

  typedef enum logic [1:0] {DIV1, DIV2, DIV3, DIV4} div_t;

  typedef struct packed {
    logic [SIDX_W-1:0] sa;
    logic [SIDX_W-1:0] sb;
    logic [1:0]        wa;
    logic [1:0]        wb;
    div_t              dv;
  } mix_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef struct packed {
    logic [OFFS_W-1:0]  offset;
    logic [RANGE_W-1:0] no_target;
  } cfg_t;

  typedef enum logic [1:0] {FR_IDLE, FR_MUL, FR_DIV, FR_DONE} fr_state_t;

  // Segment whose upper point is at or above p: count of inner points >= p.
  function automatic logic [SEG_W-1:0] seg_of(input logic [P_W-1:0] p);
    logic [NUM_POINTS-3:0] ge;
    for (int k = 1; k < NUM_POINTS - 1; k++) begin
      ge[k-1] = P_W'(PT_INT[k]) >= p;
    end
    return SEG_W'($countones(ge));
  endfunction

  function automatic logic [SPAN_W-1:0] seg_span(input logic [SEG_W-1:0] s);
    return SPAN_W'(PT_INT[s] - PT_INT[s + SEG_W'(1)]);
  endfunction

  function automatic logic [DELTA_W-1:0] seg_delta(input logic [SEG_W-1:0] s);
    return DELTA_W'(PT_DIST[s + SEG_W'(1)] - PT_DIST[s]);
  endfunction

  function automatic mix_t beam_mix(input logic [BEAM_W-1:0] b);
    mix_t m;
    unique case (b)
      5'd0:    m = '{3'd4, 3'd5, 2'd1, 2'd0, DIV1};
      5'd1:    m = '{3'd4, 3'd5, 2'd3, 2'd1, DIV4};
      5'd2:    m = '{3'd4, 3'd5, 2'd1, 2'd1, DIV2};
      5'd3:    m = '{3'd4, 3'd5, 2'd1, 2'd3, DIV4};
      5'd4:    m = '{3'd5, 3'd6, 2'd1, 2'd0, DIV1};
      5'd5:    m = '{3'd5, 3'd6, 2'd2, 2'd1, DIV3};
      5'd6:    m = '{3'd5, 3'd6, 2'd1, 2'd2, DIV3};
      5'd7:    m = '{3'd6, 3'd7, 2'd1, 2'd0, DIV1};
      5'd8:    m = '{3'd6, 3'd7, 2'd1, 2'd1, DIV2};
      5'd9:    m = '{3'd7, 3'd0, 2'd1, 2'd0, DIV1};
      5'd10:   m = '{3'd7, 3'd0, 2'd1, 2'd1, DIV2};
      5'd11:   m = '{3'd0, 3'd1, 2'd1, 2'd0, DIV1};
      5'd12:   m = '{3'd0, 3'd1, 2'd1, 2'd1, DIV2};
      5'd13:   m = '{3'd1, 3'd2, 2'd1, 2'd0, DIV1};
      5'd14:   m = '{3'd1, 3'd2, 2'd2, 2'd1, DIV3};
      5'd15:   m = '{3'd1, 3'd2, 2'd1, 2'd2, DIV3};
      5'd16:   m = '{3'd2, 3'd3, 2'd1, 2'd0, DIV1};
      5'd17:   m = '{3'd2, 3'd3, 2'd3, 2'd1, DIV4};
      5'd18:   m = '{3'd2, 3'd3, 2'd1, 2'd1, DIV2};
      5'd19:   m = '{3'd2, 3'd3, 2'd1, 2'd3, DIV4};
      5'd20:   m = '{3'd3, 3'd3, 2'd1, 2'd0, DIV1};
      default: m = '{3'd0, 3'd0, 2'd0, 2'd0, DIV1};
    endcase
    return m;
  endfunction

  function automatic logic [SUM_W-1:0] weighted(input logic [1:0] w, input range_t d);
    logic [SUM_W-1:0] r;
    case (w)
      2'd0:    r = '0;
      2'd1:    r = SUM_W'(d);
      2'd2:    r = SUM_W'(d) << 1;
      default: r = (SUM_W'(d) << 1) + SUM_W'(d);
    endcase
    return r;
  endfunction

endpackage

// File: rtl/irps_front.sv
// Front end: takes a frame, linearises the eight sensors in parallel lanes.
`timescale 1ns / 1ps
module irps_front
  import irps_pkg::*;
(
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [NUM_SENSORS-1:0][INT_W-1:0] intensity,
  input  cfg_t                              cfg,
  input  fifo_stat_t                        fifo_stat,
  output logic                              busy,
  output logic                              push,
  output frame_t                            push_data
);

  fr_state_t state, state_next;
  logic [STEP_W-1:0] step;
  logic accept;

  // per-lane registers
  logic [NUM_SENSORS-1:0]              hit;
  logic [NUM_SENSORS-1:0][DIST_W-1:0]  base;
  logic [NUM_SENSORS-1:0][DELTA_W-1:0] delta;
  logic [NUM_SENSORS-1:0][SPAN_W-1:0]  hmp;
  logic [NUM_SENSORS-1:0][SPAN_W-1:0]  span;
  logic [NUM_SENSORS-1:0][DIV_W-1:0]   rem;
  logic [NUM_SENSORS-1:0][DIV_W-1:0]   dvs;
  logic [NUM_SENSORS-1:0][QUO_W-1:0]   quo;

  // per-lane combinational values
  logic [NUM_SENSORS-1:0][P_W-1:0]     p_c;
  logic [NUM_SENSORS-1:0][P_W-1:0]     hmp_full;
  logic [NUM_SENSORS-1:0][SEG_W-1:0]   seg_c;
  logic [NUM_SENSORS-1:0]              hit_c;
  logic [NUM_SENSORS-1:0][MUL_W-1:0]   prod_c;
  logic [NUM_SENSORS-1:0]              ge_c;
  logic [NUM_SENSORS-1:0][RANGE_W:0]   sum_c;

  always_comb begin
    state_next = state;
    unique case (state)
      FR_IDLE: if (start) state_next = FR_MUL;
      FR_MUL:  state_next = FR_DIV;
      FR_DIV:  if (step == STEP_W'(QUO_W - 1)) state_next = FR_DONE;
      FR_DONE: if (!fifo_stat.full) state_next = FR_IDLE;
      default: state_next = FR_IDLE;
    endcase
  end

  always_comb begin
    busy   = (state != FR_IDLE);
    accept = (state == FR_IDLE) && start;
    push   = (state == FR_DONE) && !fifo_stat.full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FR_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      if (state == FR_DIV) step <= step + STEP_W'(1);
      else                 step <= '0;
    end
  end

  always_comb begin
    for (int l = 0; l < NUM_SENSORS; l++) begin
      p_c[l]      = P_W'(intensity[l]) * P_W'(100);
      seg_c[l]    = seg_of(p_c[l]);
      hit_c[l]    = (p_c[l] != '0) && (p_c[l] <= P_W'(PT_INT[0]));
      hmp_full[l] = P_W'(PT_INT[seg_c[l]]) - p_c[l];
      prod_c[l]   = MUL_W'(delta[l]) * MUL_W'(hmp[l]);
      ge_c[l]     = rem[l] >= dvs[l];
      // base + quotient stays below 2^17; only the no-target path can overflow
      if (hit[l]) begin
        sum_c[l] = (RANGE_W + 1)'(base[l]) + (RANGE_W + 1)'(quo[l])
                 + (RANGE_W + 1)'(cfg.offset);
      end else begin
        sum_c[l] = (RANGE_W + 1)'(cfg.no_target) + (RANGE_W + 1)'(cfg.offset);
      end
      push_data[l] = sum_c[l][RANGE_W] ? {RANGE_W{1'b1}} : sum_c[l][RANGE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < NUM_SENSORS; l++) begin
      if (accept) begin
        hit[l]   <= hit_c[l];
        base[l]  <= PT_DIST[seg_c[l]];
        delta[l] <= seg_delta(seg_c[l]);
        span[l]  <= seg_span(seg_c[l]);
        hmp[l]   <= hmp_full[l][SPAN_W-1:0];
      end
      if (state == FR_MUL) begin
        rem[l] <= hit[l] ? DIV_W'(prod_c[l][PROD_W-1:0]) : '0;
        dvs[l] <= {span[l], {(QUO_W - 1){1'b0}}};
        quo[l] <= '0;
      end else if (state == FR_DIV) begin
        if (ge_c[l]) rem[l] <= rem[l] - dvs[l];
        dvs[l] <= dvs[l] >> 1;
        quo[l] <= {quo[l][QUO_W-2:0], ge_c[l]};
      end
    end
  end

endmodule

// File: rtl/irps_fifo.sv
// Short frame queue between the linearising front end and the beam builder.
`timescale 1ns / 1ps
module irps_fifo
  import irps_pkg::*;
#(
  parameter int DEPTH = QDEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  frame_t     push_data,
  input  logic       pop,
  output frame_t     head,
  output fifo_stat_t stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  frame_t          mem [DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;

  always_comb begin
    stat.full  = (count == CW'(DEPTH));
    stat.empty = (count == '0);
    head       = mem[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      if (pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      if (push && !pop)      count <= count + CW'(1);
      else if (pop && !push) count <= count - CW'(1);
    end
  end

endmodule

// File: rtl/irps_back.sv
// Back end: blends sensor distances into 21 beams, one per cycle while the queue holds a frame.
`timescale 1ns / 1ps
module irps_back
  import irps_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  frame_t              head,
  input  fifo_stat_t          fifo_stat,
  output logic                pop,
  output logic                strobe,
  output logic [BEAM_W-1:0]   beam_index,
  output logic [RANGE_W-1:0]  range_um,
  output logic                last_beam
);

  logic [BEAM_W-1:0] beam;
  logic              issue;
  mix_t              mix;
  logic [SUM_W-1:0]  sum_c;
  logic [RANGE_W-1:0] quo_c;

  logic               s1_valid, s1_last;
  logic [SUM_W-1:0]   s1_sum;
  div_t               s1_dv;
  logic [BEAM_W-1:0]  s1_beam;

  logic               s2_valid, s2_last;
  logic [MPROD_W-1:0] s2_prod;
  logic [BEAM_W-1:0]  s2_beam;

  always_comb begin
    issue = !fifo_stat.empty;
    pop   = issue && (beam == BEAM_W'(NUM_BEAMS - 1));
    mix   = beam_mix(beam);
    sum_c = weighted(mix.wa, head[mix.sa]) + weighted(mix.wb, head[mix.sb]);
    case (s1_dv)
      DIV2:    quo_c = s1_sum[RANGE_W:1];
      DIV4:    quo_c = s1_sum[RANGE_W+1:2];
      default: quo_c = s1_sum[RANGE_W-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beam     <= '0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      strobe   <= 1'b0;
    end else begin
      if (issue) beam <= pop ? '0 : beam + BEAM_W'(1);
      s1_valid <= issue;
      s2_valid <= s1_valid;
      strobe   <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_sum  <= sum_c;
    s1_dv   <= mix.dv;
    s1_beam <= beam;
    s1_last <= (beam == BEAM_W'(NUM_BEAMS - 1));

    // thirds by reciprocal; the other divisors are shifts aligned to the same slice
    if (s1_dv == DIV3) s2_prod <= MPROD_W'(s1_sum) * MPROD_W'(RECIP3);
    else               s2_prod <= MPROD_W'(quo_c) << RECIP_SH;
    s2_beam <= s1_beam;
    s2_last <= s1_last;

    range_um   <= s2_prod[RECIP_SH +: RANGE_W];
    beam_index <= s2_beam;
    last_beam  <= s2_last;
  end

endmodule

// File: rtl/ir_proximity_scan_builder_core.sv
// Top level of the IR proximity scan builder.
`timescale 1ns / 1ps
// Turns a frame of eight raw IR proximity intensities into a 21-beam scan.
//
// Input: a frame is taken on a clock edge with start high and busy low.
// busy stays high while the eight lanes linearise the frame (table
// lookup, one multiply, a 15-step restoring divide per lane) and longer
// while the finished distances wait for room in the two-frame queue; the
// front end takes a new frame only after it has pushed the last one.
// Output: beams 0..20 leave on consecutive cycles, each valid for exactly
// one cycle with strobe high; last_beam marks beam 20. The builder emits
// one beam per cycle while the queue holds a frame; the front end runs
// ahead into the queue, so frames offered back to back stream without
// gaps. The receiver cannot stall the strobe.
// Configuration: cfg_we writes register cfg_index (0 sensor offset,
// 1 no-target distance) in the same edge; other indexes are ignored.
// Write only while idle.
// Reset (synchronous) empties the queue, stops any frame in flight and
// restores the register defaults.
module ir_proximity_scan_builder_core
  import irps_pkg::*;
#(
  parameter int QDEPTH = QDEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [INT_W-1:0]     intensity_0,
  input  logic [INT_W-1:0]     intensity_1,
  input  logic [INT_W-1:0]     intensity_2,
  input  logic [INT_W-1:0]     intensity_3,
  input  logic [INT_W-1:0]     intensity_4,
  input  logic [INT_W-1:0]     intensity_5,
  input  logic [INT_W-1:0]     intensity_6,
  input  logic [INT_W-1:0]     intensity_7,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output logic                 strobe,
  output logic [BEAM_W-1:0]    beam_index,
  output logic [RANGE_W-1:0]   range_um,
  output logic                 last_beam
);

  logic [OFFS_W-1:0]  sensor_offset_um;
  logic [RANGE_W-1:0] no_target_um;
  cfg_t               cfg;
  logic [NUM_SENSORS-1:0][INT_W-1:0] intensity;

  logic       push, pop;
  frame_t     push_data, head;
  fifo_stat_t fifo_stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_offset_um <= SENSOR_OFFSET_RST;
      no_target_um     <= NO_TARGET_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SENSOR_OFFSET: sensor_offset_um <= cfg_data[OFFS_W-1:0];
        REG_NO_TARGET:     no_target_um     <= cfg_data[RANGE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.offset    = sensor_offset_um;
    cfg.no_target = no_target_um;
    intensity     = {intensity_7, intensity_6, intensity_5, intensity_4,
                     intensity_3, intensity_2, intensity_1, intensity_0};
  end

  irps_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .intensity (intensity),
    .cfg       (cfg),
    .fifo_stat (fifo_stat),
    .busy      (busy),
    .push      (push),
    .push_data (push_data)
  );

  irps_fifo #(.DEPTH(QDEPTH)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .stat      (fifo_stat)
  );

  irps_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .fifo_stat  (fifo_stat),
    .pop        (pop),
    .strobe     (strobe),
    .beam_index (beam_index),
    .range_um   (range_um),
    .last_beam  (last_beam)
  );

endmodule

// File: rtl/irps_checker.sv
// Port-level checks for the scan builder, bound to the top level.
`timescale 1ns / 1ps
module irps_checker
  import irps_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              strobe,
  input logic [BEAM_W-1:0] beam_index,
  input logic              last_beam
);

  // last_beam flags the final beam and nothing else
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (last_beam == (beam_index == BEAM_W'(NUM_BEAMS - 1))))
    else $error("last_beam does not match beam_index");

  // beams of one scan come on consecutive cycles in order
  a_beam_seq: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last_beam) |=> (strobe && (beam_index == $past(beam_index) + BEAM_W'(1))))
    else $error("scan beams not contiguous");

  // a scan can only begin with beam zero
  a_scan_start: assert property (@(posedge clk) disable iff (rst)
    $rose(strobe) |-> (beam_index == '0))
    else $error("scan started mid-way");

  // an accepted item keeps the front end occupied
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after an item was taken");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> (!strobe && !busy))
    else $error("outputs active after reset");

endmodule

bind ir_proximity_scan_builder_core irps_checker u_checker (.*);
